### hdl/cett_pkg.sv
// Shared types and codes for the chained event timer table.
`default_nettype none

package cett_pkg;

  // Width of the flag-update indices (up to 256 events); input items carry a 4-bit event index
  localparam int IDX_W = 8;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_SIGNAL  = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_MESSAGE = 2'd2,
    ACT_SWITCH  = 2'd3
  } action_t;

  // Enable flag update: clear is applied before set
  typedef struct packed {
    logic             clr;
    logic [IDX_W-1:0] clr_idx;
    logic             set;
    logic [IDX_W-1:0] set_idx;
  } flag_upd_t;

endpackage

`default_nettype wire

### hdl/chained_event_timer_table.sv
// Path: RAM read into the compute stage, then the output register. Throughput: one item per
// cycle unless the output stalls; the descriptor RAM is read at input transfer and written
// back when the item leaves the compute stage, with a one-entry forwarding register.
// Reset: clears the enable flags and the pipeline valids; descriptor RAM is not cleared
// and holds undefined data until a load item writes an entry.
`default_nettype none

module chained_event_timer_table import cett_pkg::*; #(
  parameter int NUM_EVENTS    = 16,
  parameter int COUNTER_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // event_index[3:0], threshold[11:4], repeat_mode[12], action[14:13], target[22:15],
  // enable_now[23]
  input  wire logic [23:0] in_tdata,
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  input  wire logic        in_tlast,   // sweep_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // fired_index[3:0], fired_action[5:4], task_mask[13:6], zero[15:14]
  output logic      [15:0] out_tdata,
  output logic             out_tuser,  // fired
  output logic             out_tlast   // sweep_done
);

  localparam int AW = $clog2(NUM_EVENTS);
  localparam int CW = COUNTER_WIDTH;
  localparam int TW = (CW > 8) ? CW : 8;
  // descriptor word: target[7:0], action[9:8], repeat[10], reload[18:11], counter[top]
  localparam int WW = CW + 19;

  // compute stage
  logic          s1_v_r;
  opcode_t       s1_op_r;
  logic [3:0]    s1_idx_r;
  logic [7:0]    s1_thr_r;
  logic          s1_rep_r;
  logic [1:0]    s1_act_r;
  logic [7:0]    s1_tgt_r;
  logic          s1_en_r;
  logic          s1_last_r;

  // output register
  logic          out_v_r;
  logic          out_fired_r;
  logic [3:0]    out_idx_r;
  logic [1:0]    out_act_r;
  logic [7:0]    out_mask_r;
  logic          out_last_r;

  // last write, forwarded to a read issued on the same edge
  logic          fwd_v_r;
  logic [AW-1:0] fwd_addr_r;
  logic [WW-1:0] fwd_data_r;

  logic          in_acc;
  logic          s1_adv;
  logic [7:0]    in_idx8;
  logic [7:0]    s1_idx8;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] s1_addr;
  logic          s1_inr;
  logic [WW-1:0] ram_rdata;
  logic [WW-1:0] word;
  logic [CW-1:0] w_cnt;
  logic [7:0]    w_rel;
  logic          w_rep;
  logic [1:0]    w_act;
  logic [7:0]    w_tgt;
  logic [CW-1:0] cnt_dec;
  logic [TW-1:0] rel_ext;
  logic [TW-1:0] thr_ext;
  logic          tgt_inr;
  logic          flag_en;
  logic          wr_en;
  logic [WW-1:0] wr_data;
  logic          fire;
  logic [7:0]    mask;
  flag_upd_t     upd;

  assign in_acc    = in_tvalid && in_tready;
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  assign in_idx8 = 8'(in_tdata[3:0]);
  assign s1_idx8 = 8'(s1_idx_r);
  assign rd_addr = in_idx8[AW-1:0];
  assign s1_addr = s1_idx8[AW-1:0];
  assign s1_inr  = 9'(s1_idx_r) < 9'(NUM_EVENTS);

  assign word    = (fwd_v_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : ram_rdata;
  assign w_cnt   = word[WW-1:19];
  assign w_rel   = word[18:11];
  assign w_rep   = word[10];
  assign w_act   = word[9:8];
  assign w_tgt   = word[7:0];
  assign cnt_dec = w_cnt - CW'(1);
  assign rel_ext = TW'(w_rel);
  assign thr_ext = TW'(s1_thr_r);
  assign tgt_inr = {1'b0, w_tgt} < 9'(NUM_EVENTS);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = {thr_ext[CW-1:0], s1_thr_r, s1_rep_r, s1_act_r, s1_tgt_r};
    fire    = 1'b0;
    mask    = '0;
    upd     = '0;
    if (s1_inr) begin
      unique case (s1_op_r)
        OP_LOAD: begin
          wr_en       = 1'b1;
          upd.set     = s1_en_r;
          upd.set_idx = s1_idx8;
          upd.clr     = !s1_en_r;
          upd.clr_idx = s1_idx8;
        end
        OP_ENABLE: begin
          upd.set     = 1'b1;
          upd.set_idx = s1_idx8;
        end
        OP_DISABLE: begin
          upd.clr     = 1'b1;
          upd.clr_idx = s1_idx8;
        end
        OP_TICK: begin
          if (flag_en) begin
            wr_en = 1'b1;
            fire  = (cnt_dec == '0);
            // free-running events reload on expiry, even after a switch
            wr_data = {(fire && w_rep) ? rel_ext[CW-1:0] : cnt_dec, word[18:0]};
            if (fire && (w_act == ACT_RELEASE)) begin
              mask = w_tgt;
            end
            if (fire && (w_act == ACT_SWITCH)) begin
              upd.clr     = 1'b1;
              upd.clr_idx = s1_idx8;
              upd.set     = tgt_inr;
              upd.set_idx = w_tgt;
            end
          end
        end
        default: ;
      endcase
    end
  end

  cett_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_EVENTS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (s1_adv && wr_en),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  cett_flags #(
    .NUM_EVENTS (NUM_EVENTS)
  ) u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_en  (s1_adv),
    .upd     (upd),
    .rd_idx  (s1_addr),
    .rd_flag (flag_en)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (s1_adv && wr_en) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= opcode_t'(in_tuser);
      s1_idx_r  <= in_tdata[3:0];
      s1_thr_r  <= in_tdata[11:4];
      s1_rep_r  <= in_tdata[12];
      s1_act_r  <= in_tdata[14:13];
      s1_tgt_r  <= in_tdata[22:15];
      s1_en_r   <= in_tdata[23];
      s1_last_r <= in_tlast;
    end
    if (s1_adv) begin
      out_fired_r <= fire;
      out_idx_r   <= s1_idx_r;
      out_act_r   <= fire ? w_act : 2'd0;
      out_mask_r  <= mask;
      out_last_r  <= (s1_op_r == OP_TICK) ? s1_last_r : 1'b0;
    end
    if (s1_adv && wr_en) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= wr_data;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_mask_r, out_act_r, out_idx_r};
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // a result that did not fire carries no action and no mask
  a_nofire_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[13:4] == '0))
    else $error("non-fired result carries action or mask");

  // descriptor writes only happen as an item leaves the compute stage
  a_write_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && wr_en) |-> s1_v_r)
    else $error("descriptor write without a valid item");

  // a new item never overwrites one still waiting in the compute stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_v_r) |-> s1_adv)
    else $error("compute stage overrun");

  // every descriptor write is held for forwarding
  a_fwd_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && wr_en) |=> (fwd_v_r && (fwd_addr_r == $past(s1_addr))))
    else $error("forwarding register missed a write");
`endif

endmodule

`default_nettype wire

### hdl/cett_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/cett_flags.sv
// Per-event enable flags, cleared at reset.
`default_nettype none

module cett_flags import cett_pkg::*; #(
  parameter int NUM_EVENTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          upd_en,
  input  wire flag_upd_t                     upd,
  input  wire logic [$clog2(NUM_EVENTS)-1:0] rd_idx,
  output logic                               rd_flag
);

  localparam int AW = $clog2(NUM_EVENTS);

  logic [NUM_EVENTS-1:0] flags_r;
  logic [NUM_EVENTS-1:0] flags_nxt;

  always_comb begin
    flags_nxt = flags_r;
    if (upd_en && upd.clr) begin
      flags_nxt[upd.clr_idx[AW-1:0]] = 1'b0;
    end
    // set wins, so a switch to itself leaves the event enabled
    if (upd_en && upd.set) begin
      flags_nxt[upd.set_idx[AW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  assign rd_flag = flags_r[rd_idx];

endmodule

`default_nettype wire
